[rtl/core/modexp_pkg.sv]
// modexp_pkg: shared constants for the modular exponentiation core
// no dependencies
package modexp_pkg;
  localparam int unsigned Width = 32;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegExponent = 1'b0;
  localparam logic [CfgIdxW-1:0] RegModulus  = 1'b1;
endpackage

[rtl/core/modexp_cell.sv]
// modexp_cell: one bit slice of the shift-add modular multiplier
// depends on: nothing; a chain of these forms a carry-ripple stage per cycle
module modexp_cell (
  input  logic r_lo_i,    // next lower residue bit (for doubling)
  input  logic a_i,       // addend bit
  input  logic m_i,       // modulus bit
  input  logic add_en_i,
  input  logic c1_i,      // carry of r*2 (+a)
  input  logic b1_i,      // borrow of sum - m
  output logic c1_o,
  output logic b1_o,
  output logic s_o,       // raw sum bit
  output logic d_o        // sum - m bit
);
  logic x, y;
  always_comb begin
    x = r_lo_i;
    y = a_i & add_en_i;
    s_o  = x ^ y ^ c1_i;
    c1_o = (x & y) | (x & c1_i) | (y & c1_i);
    d_o  = s_o ^ m_i ^ b1_i;
    b1_o = (~s_o & m_i) | (~s_o & b1_i) | (m_i & b1_i);
  end
endmodule

[rtl/core/modexp_mulmod.sv]
// modexp_mulmod: bit-serial modular multiplier built from a chain of cells
// depends on: modexp_cell
module modexp_mulmod #(
  parameter int unsigned Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  input  logic [Width-1:0] m_i,
  output logic             done_o,
  output logic [Width-1:0] r_o
);
  localparam int unsigned CntW = $clog2(Width + 1);
  // each multiplier bit takes a double-reduce step, then an add-reduce step if the bit is set
  logic [Width-1:0] r_q, r_d, b_q, b_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             phase_q, phase_d, busy_q, busy_d, done_q, done_d;

  logic [Width:0]   c, bw;
  logic [Width-1:0] s, dd;
  logic [Width:0]   rsh;
  logic             add_en;

  assign add_en = phase_q;
  assign rsh    = phase_q ? {1'b0, r_q} : {r_q, 1'b0};
  assign c[0]   = 1'b0;
  assign bw[0]  = 1'b0;

  for (genvar i = 0; i < Width; i++) begin : g_cell
    modexp_cell u_cell (
      .r_lo_i(rsh[i]), .a_i(a_i[i]), .m_i(m_i[i]),
      .add_en_i(add_en), .c1_i(c[i]), .b1_i(bw[i]),
      .c1_o(c[i+1]), .b1_o(bw[i+1]), .s_o(s[i]), .d_o(dd[i])
    );
  end

  logic sum_hi, ge;
  always_comb begin
    sum_hi = c[Width] | (~phase_q & rsh[Width]);
    // sum >= m when the sum overflowed width or no borrow out
    ge = sum_hi | ~bw[Width];
    r_d = r_q; b_d = b_q; cnt_d = cnt_q; phase_d = phase_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      r_d = '0; b_d = b_i; cnt_d = CntW'(Width); phase_d = 1'b0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!phase_q) begin
        r_d = ge ? dd : s;
        phase_d = b_q[Width-1];
        if (!b_q[Width-1]) begin
          b_d = b_q << 1;
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) begin busy_d = 1'b0; done_d = 1'b1; end
        end
      end else begin
        r_d = ge ? dd : s;
        phase_d = 1'b0;
        b_d = b_q << 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin busy_d = 1'b0; done_d = 1'b1; end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; phase_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; phase_q <= phase_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    r_q <= r_d; b_q <= b_d;
  end
  assign done_o = done_q;
  assign r_o    = r_q;
endmodule

[rtl/core/modular_exponentiation_core.sv]
// modular_exponentiation_core: top level, square-and-multiply sequencer
// depends on: modexp_pkg, modexp_mulmod (chain of modexp_cell)
//
// Usage: write exponent (index 0) and modulus (index 1) on the config port
// while idle; both reset to 1. Input transactions carry value_i and
// end_of_message_i on valid_i/stall_o; one result leaves on valid_o/stall_i
// with the flag copied through.
// Each transaction with a nonzero exponent and a modulus above 1 starts
// by reducing value mod modulus through the shared multiplier (1*value),
// then per exponent bit runs an optional multiply and a square. A multiply
// runs a doubling step per multiplier bit plus an add step per set bit,
// each through the cell chain. A zero exponent answers 1; otherwise a
// modulus of 0 or 1 answers 0; neither case uses the multiplier.
// The multiplier is the one shared unit, so one item is processed at a time.
// A finished result sits in the output register until taken; a new input is
// accepted while it waits and holds its result until the register frees.
// Reset clears all control state and drops valid_o.
module modular_exponentiation_core #(
  parameter int unsigned Width = modexp_pkg::Width
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [modexp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [Width-1:0]              cfg_data_i,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [Width-1:0]              value_i,
  input  logic                          end_of_message_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [Width-1:0]              result_value_o,
  output logic                          end_of_message_out_o
);
  typedef enum logic [5:0] {
    StIdle = 6'b000001, StRed = 6'b000010, StMul = 6'b000100,
    StSqr  = 6'b001000, StNext = 6'b010000, StFin = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [Width-1:0] exp_q, mod_q, e_q, e_d, base_q, base_d, acc_q, acc_d;
  logic [Width-1:0] res_q, res_d;
  logic eom_q, eom_d, oeom_q, oeom_d, ovalid_q, ovalid_d;
  logic start;
  logic [Width-1:0] ma, mb;
  logic mdone;
  logic [Width-1:0] mr;

  modexp_mulmod #(.Width(Width)) u_mul (
    .clk_i, .rst_ni, .start_i(start), .a_i(ma), .b_i(mb), .m_i(mod_q),
    .done_o(mdone), .r_o(mr)
  );

  assign stall_o = (state_q != StIdle);
  logic take_out;
  assign take_out = ovalid_q & ~stall_i;

  always_comb begin
    state_d = state_q; e_d = e_q; base_d = base_q; acc_d = acc_q;
    eom_d = eom_q; res_d = res_q; oeom_d = oeom_q;
    ovalid_d = ovalid_q & ~take_out;
    start = 1'b0; ma = base_q; mb = base_q;
    case (state_q)
      StIdle: begin
        // value enters as the serial operand so any value reduces fully
        ma = Width'(1); mb = value_i;
        if (valid_i) begin
          e_d = exp_q; base_d = value_i; eom_d = end_of_message_i;
          if (exp_q == '0) begin
            acc_d = Width'(1); state_d = StFin;
          end else if (mod_q <= Width'(1)) begin
            acc_d = '0; state_d = StFin;
          end else begin
            acc_d = Width'(1); start = 1'b1; state_d = StRed;
          end
        end
      end
      StRed: begin
        ma = Width'(1);
        if (mdone) begin
          base_d = mr; state_d = StNext;
        end
      end
      StNext: begin
        if (e_q == '0) state_d = StFin;
        else if (e_q[0]) begin
          ma = acc_q; mb = base_q; start = 1'b1; state_d = StMul;
        end else begin
          start = 1'b1; state_d = StSqr;
        end
      end
      StMul: begin
        ma = acc_q;
        if (mdone) begin
          acc_d = mr; start = 1'b1; state_d = StSqr;
        end
      end
      StSqr: if (mdone) begin
        base_d = mr; e_d = e_q >> 1; state_d = StNext;
      end
      StFin: if (!ovalid_q || take_out) begin
        res_d = acc_q; oeom_d = eom_q; ovalid_d = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; ovalid_q <= 1'b0;
      exp_q <= Width'(1); mod_q <= Width'(1);
    end else begin
      state_q <= state_d; ovalid_q <= ovalid_d;
      if (cfg_we_i && cfg_idx_i == modexp_pkg::RegExponent) exp_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == modexp_pkg::RegModulus)  mod_q <= cfg_data_i;
    end
  end
  always_ff @(posedge clk_i) begin
    e_q <= e_d; base_q <= base_d; acc_q <= acc_d; eom_q <= eom_d;
    res_q <= res_d; oeom_q <= oeom_d;
  end

  assign valid_o = ovalid_q;
  assign result_value_o = res_q;
  assign end_of_message_out_o = oeom_q;
endmodule
